/* hw/rtl/esp_pkg.sv */
package esp_pkg;

	// Configuration port geometry
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Register indexes on the configuration port
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DRIVE_ATTACHED      = 3'd0,
		REG_CURRENT_THRESHOLD   = 3'd1,
		REG_MIN_DEMANDED_SPEED  = 3'd2,
		REG_MIN_POSITION_ERROR  = 3'd3,
		REG_MAX_STILL_EXCURSION = 3'd4,
		REG_WINDOW_TICKS        = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic        drive_attached;
		logic [14:0] current_threshold;
		logic [14:0] min_demanded_speed;
		logic [14:0] min_position_error;
		logic [15:0] max_still_excursion;
		logic [15:0] window_ticks;
	} cfg_t;

	typedef struct packed {
		logic               drive_enabled;
		logic signed [15:0] torque_current;
		logic signed [15:0] demanded_speed;
		logic signed [15:0] position_error;
		logic        [15:0] encoder_angle;
	} in_word_t;

	typedef struct packed {
		logic        encoder_loss;
		logic [15:0] still_count;
	} out_word_t;

	// Magnitude of a signed 16-bit value; full-scale negative gives 32768
	function automatic logic [15:0] mag16(input logic signed [15:0] v);
		logic [15:0] u;
		u = v;
		return u[15] ? (~u + 16'd1) : u;
	endfunction

endpackage

/* hw/rtl/esp_if.sv */
// Input word channel: one evaluation tick
interface esp_in_if;
	logic               valid;
	logic               ready;
	logic               drive_enabled;
	logic signed [15:0] torque_current;
	logic signed [15:0] demanded_speed;
	logic signed [15:0] position_error;
	logic        [15:0] encoder_angle;

	modport source (
		output valid, drive_enabled, torque_current, demanded_speed,
		       position_error, encoder_angle,
		input  ready
	);
	modport sink (
		input  valid, drive_enabled, torque_current, demanded_speed,
		       position_error, encoder_angle,
		output ready
	);
endinterface

// Result word channel
interface esp_out_if;
	logic        valid;
	logic        ready;
	logic        encoder_loss;
	logic [15:0] still_count;

	modport source (output valid, encoder_loss, still_count, input ready);
	modport sink (input valid, encoder_loss, still_count, output ready);
endinterface

/* hw/rtl/esp_cfg.sv */
module esp_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [esp_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [esp_pkg::CFG_DATA_W-1:0]      cfg_data,
	output esp_pkg::cfg_t                       cfg
);
	import esp_pkg::*;

	cfg_t cfg_q;

	// Write the addressed register; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drive_attached      <= 1'b0;
			cfg_q.current_threshold   <= '0;
			cfg_q.min_demanded_speed  <= '0;
			cfg_q.min_position_error  <= '0;
			cfg_q.max_still_excursion <= '0;
			cfg_q.window_ticks        <= 16'd1;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_DRIVE_ATTACHED:      cfg_q.drive_attached      <= cfg_data[0];
				REG_CURRENT_THRESHOLD:   cfg_q.current_threshold   <= cfg_data[14:0];
				REG_MIN_DEMANDED_SPEED:  cfg_q.min_demanded_speed  <= cfg_data[14:0];
				REG_MIN_POSITION_ERROR:  cfg_q.min_position_error  <= cfg_data[14:0];
				REG_MAX_STILL_EXCURSION: cfg_q.max_still_excursion <= cfg_data;
				REG_WINDOW_TICKS:        cfg_q.window_ticks        <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hw/rtl/esp_eval.sv */
module esp_eval #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  esp_pkg::cfg_t       cfg,
	input  logic                step,
	input  esp_pkg::in_word_t   word_s1,
	output esp_pkg::out_word_t  result
);
	import esp_pkg::*;

	// Compare width covers both the angle and the 16-bit excursion limit
	localparam int CMP_W = (ANGLE_BITS > 16) ? ANGLE_BITS : 16;

	logic                  tracking_q, tracking_n;
	logic [ANGLE_BITS-1:0] anchor_q, anchor_n;
	logic [15:0]           still_q, still_n;
	logic                  latched_q, latched_n;
	logic                  loss;

	logic [CMP_W-1:0]      angle_ext;
	logic [ANGLE_BITS-1:0] reading;
	logic [ANGLE_BITS-1:0] delta;
	logic [ANGLE_BITS-1:0] excursion;
	logic                  pushing;
	logic                  demanding;
	logic                  moved;
	logic [15:0]           still_inc;

	// Wrapped excursion from the anchor
	assign angle_ext = CMP_W'(word_s1.encoder_angle);
	assign reading   = angle_ext[ANGLE_BITS-1:0];
	assign delta     = reading - anchor_q;
	assign excursion = delta[ANGLE_BITS-1] ? (~delta + 1'b1) : delta;
	assign moved     = CMP_W'(excursion) >= CMP_W'(cfg.max_still_excursion);

	// Drive effort checks
	assign pushing   = mag16(word_s1.torque_current) >= {1'b0, cfg.current_threshold};
	assign demanding = (mag16(word_s1.demanded_speed) >= {1'b0, cfg.min_demanded_speed}) ||
	                   (mag16(word_s1.position_error) >= {1'b0, cfg.min_position_error});

	// Saturating still counter
	assign still_inc = (still_q != 16'hFFFF) ? (still_q + 16'd1) : still_q;

	// Next state for this tick
	always_comb begin
		tracking_n = tracking_q;
		anchor_n   = anchor_q;
		still_n    = still_q;
		latched_n  = latched_q;
		loss       = 1'b0;
		if (cfg.drive_attached) begin
			if (!word_s1.drive_enabled) begin
				tracking_n = 1'b0;
				still_n    = '0;
				latched_n  = 1'b0;
			end else if (latched_q || !(pushing && demanding)) begin
				tracking_n = 1'b0;
				still_n    = '0;
			end else if (!tracking_q || moved) begin
				anchor_n   = reading;
				still_n    = '0;
				tracking_n = 1'b1;
			end else if (still_inc >= cfg.window_ticks) begin
				latched_n  = 1'b1;
				tracking_n = 1'b0;
				still_n    = '0;
				loss       = 1'b1;
			end else begin
				still_n    = still_inc;
			end
		end
	end

	// Advance the tracking state once per evaluated word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q <= 1'b0;
			anchor_q   <= '0;
			still_q    <= '0;
			latched_q  <= 1'b0;
		end else if (step) begin
			tracking_q <= tracking_n;
			anchor_q   <= anchor_n;
			still_q    <= still_n;
			latched_q  <= latched_n;
		end
	end

	assign result.encoder_loss = loss;
	assign result.still_count  = still_n;

endmodule

/* hw/rtl/encoder_stall_plausibility_monitor.sv */
// Encoder stall plausibility monitor.
// The sample channel takes one evaluation tick per word: drive enable, torque
// current, demanded speed, position error and encoder angle. The result
// channel returns one word per sample: the encoder loss pulse and the still
// tick count after that tick. Thresholds, excursion limit and window length
// are written through the configuration port; the user must do so only while
// no sample is in flight, as the block itself does not enforce it.
// A result word passes through the input register, then the evaluation logic
// feeding the result register.
// Throughput: one sample per cycle while the receiver takes results, set by the
// single evaluation stage whose tracking state is read and updated in the same cycle.
// Reset clears the pipeline, the tracking state and the loss latch, and
// loads the register defaults (window of one tick, every other register 0).
// When the receiver stalls, the result register holds its word; the input
// register still takes one more sample, and then sample ready drops until
// the result is taken.
module encoder_stall_plausibility_monitor #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	esp_in_if.sink                             sample,
	esp_out_if.source                          result,
	input  logic                               cfg_wr_en,
	input  logic [esp_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [esp_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import esp_pkg::*;

	cfg_t      cfg;
	in_word_t  word_s1;
	logic      valid_s1;
	out_word_t eval_res;
	out_word_t res_s2;
	logic      valid_s2;
	logic      advance;
	logic      step;

	esp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Pipeline moves when the result register is free or being emptied
	assign advance      = !valid_s2 || result.ready;
	assign step         = valid_s1 && advance;
	assign sample.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			word_s1.drive_enabled  <= sample.drive_enabled;
			word_s1.torque_current <= sample.torque_current;
			word_s1.demanded_speed <= sample.demanded_speed;
			word_s1.position_error <= sample.position_error;
			word_s1.encoder_angle  <= sample.encoder_angle;
		end
	end

	esp_eval #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_eval (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.step    (step),
		.word_s1 (word_s1),
		.result  (eval_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= eval_res;
		end
	end

	assign result.valid        = valid_s2;
	assign result.encoder_loss = res_s2.encoder_loss;
	assign result.still_count  = res_s2.still_count;

endmodule

/* hw/rtl/esp_checker.sv */
module esp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        sample_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic        result_loss,
	input logic [15:0] result_count
);

	// A loss word always reports a cleared counter
	a_loss_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_loss |-> result_count == 16'd0)
		else $error("loss word with nonzero still count");

	// The latch blocks a second loss pulse on the following word
	a_no_double_loss: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && result_loss |=> !(result_valid && result_loss))
		else $error("loss reported on two words in a row");

	// Sample side stays open whenever the result side is not stalled
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!result_valid || result_ready) |-> sample_ready)
		else $error("sample ready low with free result side");

	// A stalled result word holds
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_count)
		&& $stable(result_loss))
		else $error("stalled result word changed");

endmodule

bind encoder_stall_plausibility_monitor esp_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_ready (sample.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_loss  (result.encoder_loss),
	.result_count (result.still_count)
);
